@@ rtl/rtp_header_parser_unit_defines.svh @@
// Assertion macros shared by the RTP header parser checker.
// No dependencies; each macro expects clk and rst in scope.
`ifndef RTP_HEADER_PARSER_UNIT_DEFINES_SVH
`define RTP_HEADER_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define RTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define RTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rtp_hp_pkg.sv @@
// Package for the RTP header parser: word types, status codes, register indexes.
// No dependencies; used by every module of the parser.
package rtp_hp_pkg;

  localparam int DEF_MAX_PACKET_BYTES = 65535;
  localparam int DEF_QUEUE_DEPTH      = 2;
  localparam int LEN_W                = 16;
  localparam int HDR_W                = 19;

  localparam logic [7:0] RAW_TS_SYNC  = 8'h47;
  localparam logic [1:0] RTP_VERSION  = 2'b10;
  localparam int         HDR_FIXED    = 12;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RAW_TS    = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_BAD_VER   = 3'd3;
  localparam logic [2:0] ST_HDR_LONG  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_LENGTH      = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_TYPE   = 2'd1;
  localparam logic [1:0] CFG_RETRANSMIT_TYPE = 2'd2;

  localparam logic [15:0] RST_MIN_LENGTH      = 16'd188;
  localparam logic [6:0]  RST_EXPECTED_TYPE   = 7'h21;
  localparam logic [6:0]  RST_RETRANSMIT_TYPE = 7'h60;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             first_byte;
    logic             last_byte;
    logic [LEN_W-1:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [HDR_W-1:0] header_length;
    logic [15:0]      seq_number;
    logic [31:0]      sync_source;
    logic             type_unexpected;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] min_length;
    logic [6:0]       expected_type;
    logic [6:0]       retransmit_type;
  } cfg_t;

  // packet summary handed from the front to the back
  typedef struct packed {
    logic [2:0]       status;
    logic [HDR_W-1:0] header_end;
    logic [15:0]      seq;
    logic [31:0]      ssrc;
    logic [6:0]       kind;
  } record_t;

endpackage

@@ rtl/rtp_hp_front.sv @@
// Front of the RTP header parser: takes one byte a word, tracks header fields,
// classifies the packet and pushes a summary on the final byte. Uses rtp_hp_pkg.
module rtp_hp_front #(
  parameter int MAX_PACKET_BYTES = rtp_hp_pkg::DEF_MAX_PACKET_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rtp_hp_pkg::in_item_t in_data,
  input  rtp_hp_pkg::cfg_t    cfg,
  input  logic                full,
  output logic                push,
  output rtp_hp_pkg::record_t rec
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int LW = rtp_hp_pkg::LEN_W;
  localparam int HW = rtp_hp_pkg::HDR_W;

  logic [PW-1:0] position;
  logic [LW-1:0] length_seen;
  logic [HW-1:0] header_end;
  logic [3:0]    csrc_count;
  logic          extension_flag;
  logic [6:0]    payload_kind;
  logic [15:0]   seq_hold;
  logic [31:0]   ssrc_hold;
  logic [2:0]    status_hold;

  logic          accept;
  logic [7:0]    b;
  logic [3:0]    cc_e;
  logic          x_e;
  logic [6:0]    base;
  logic [HW-1:0] he_e, he_n;
  logic [LW-1:0] len_e;
  logic [2:0]    st_first, st_e, st_cur, st_final;
  logic [15:0]   p16;
  logic [PW-1:0] p_e, pos_adv;
  logic [6:0]    kind_e, kind_n;
  logic [15:0]   seq_e, seq_n;
  logic [31:0]   ssrc_e, ssrc_n;

  assign in_stall = full;
  assign accept   = in_valid & ~full;
  assign b        = in_data.data_byte;

  always_comb begin
    cc_e   = in_data.first_byte ? b[3:0] : csrc_count;
    x_e    = in_data.first_byte ? b[4] : extension_flag;
    base   = 7'(rtp_hp_pkg::HDR_FIXED) + {1'b0, cc_e, 2'b00};
    he_e   = in_data.first_byte ? (HW'(base) + (x_e ? HW'(4) : '0)) : header_end;
    len_e  = in_data.first_byte ? in_data.packet_length : length_seen;
    kind_e = in_data.first_byte ? 7'd0 : payload_kind;
    seq_e  = in_data.first_byte ? 16'd0 : seq_hold;
    ssrc_e = in_data.first_byte ? 32'd0 : ssrc_hold;
    p_e    = in_data.first_byte ? '0 : position;
    p16    = 16'(p_e);

    // classification of a new packet, in priority order
    if (in_data.packet_length < cfg.min_length) begin
      st_first = rtp_hp_pkg::ST_SHORT;
    end else if (b == rtp_hp_pkg::RAW_TS_SYNC) begin
      st_first = rtp_hp_pkg::ST_RAW_TS;
    end else if (b[7:6] != rtp_hp_pkg::RTP_VERSION) begin
      st_first = rtp_hp_pkg::ST_BAD_VER;
    end else if (16'(base) + 16'd4 >= in_data.packet_length) begin
      st_first = rtp_hp_pkg::ST_HDR_LONG;
    end else begin
      st_first = rtp_hp_pkg::ST_OK;
    end
    if ((17'(in_data.packet_length) > 17'(MAX_PACKET_BYTES)) &&
        (st_first <= rtp_hp_pkg::ST_RAW_TS)) begin
      st_first = rtp_hp_pkg::ST_TRUNCATED;
    end

    st_e = in_data.first_byte ? st_first : status_hold;
    if ((p16 >= len_e) && (st_e <= rtp_hp_pkg::ST_RAW_TS)) begin
      st_cur = rtp_hp_pkg::ST_TRUNCATED;
    end else begin
      st_cur = st_e;
    end

    kind_n = kind_e;
    seq_n  = seq_e;
    ssrc_n = ssrc_e;
    if (p16 == 16'd1) begin
      kind_n = b[6:0];
    end else if (p16 inside {16'd2, 16'd3}) begin
      seq_n = {seq_e[7:0], b};
    end else if (p16 inside {[16'd8:16'd11]}) begin
      ssrc_n = {ssrc_e[23:0], b};
    end

    // extension length word: 4 bytes per word on top of the fixed part
    he_n = he_e;
    if (x_e) begin
      if (p16 == 16'(base) + 16'd2) begin
        he_n = he_e + HW'({b, 10'b0});
      end else if (p16 == 16'(base) + 16'd3) begin
        he_n = he_e + HW'({b, 2'b0});
      end
    end

    // retransmission: original sequence number follows the header
    if ((p16 >= 16'd4) && ((HW'(p16) == he_n) || (HW'(p16) == he_n + HW'(1))) &&
        (kind_n == cfg.retransmit_type)) begin
      seq_n = {seq_n[7:0], b};
    end

    pos_adv = (p_e < PW'(MAX_PACKET_BYTES)) ? p_e + PW'(1) : PW'(MAX_PACKET_BYTES);

    if ((st_cur <= rtp_hp_pkg::ST_RAW_TS) && (16'(pos_adv) != len_e)) begin
      st_final = rtp_hp_pkg::ST_TRUNCATED;
    end else begin
      st_final = st_cur;
    end
  end

  assign push            = accept & in_data.last_byte;
  assign rec.status      = st_final;
  assign rec.header_end  = he_n;
  assign rec.seq         = seq_n;
  assign rec.ssrc        = ssrc_n;
  assign rec.kind        = kind_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      length_seen    <= '0;
      header_end     <= '0;
      csrc_count     <= '0;
      extension_flag <= 1'b0;
      payload_kind   <= '0;
      seq_hold       <= '0;
      ssrc_hold      <= '0;
      status_hold    <= rtp_hp_pkg::ST_OK;
    end else if (accept) begin
      csrc_count     <= cc_e;
      extension_flag <= x_e;
      header_end     <= he_n;
      payload_kind   <= kind_n;
      seq_hold       <= seq_n;
      ssrc_hold      <= ssrc_n;
      if (in_data.last_byte) begin
        // drop the packet; stray bytes count toward an empty one
        position    <= '0;
        length_seen <= '0;
        status_hold <= rtp_hp_pkg::ST_OK;
      end else begin
        position    <= pos_adv;
        length_seen <= len_e;
        status_hold <= st_cur;
      end
    end
  end

endmodule

@@ rtl/rtp_hp_queue.sv @@
// Short queue of packet summaries between front and back of the parser.
// Uses rtp_hp_pkg for the summary type.
module rtp_hp_queue #(
  parameter int DEPTH = rtp_hp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rtp_hp_pkg::record_t wr_rec,
  input  logic                pop,
  output logic                rd_valid,
  output rtp_hp_pkg::record_t rd_rec,
  output logic                full
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  rtp_hp_pkg::record_t store [DEPTH];
  logic [PTRW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;

  assign rd_valid = (count != '0);
  assign full     = (count == CNTW'(DEPTH));
  assign rd_rec   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + PTRW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

@@ rtl/rtp_hp_back.sv @@
// Back of the RTP header parser: formats a packet summary into a result word
// and holds it in the output register. Uses rtp_hp_pkg.
module rtp_hp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_valid,
  input  rtp_hp_pkg::record_t   rd_rec,
  output logic                  pop,
  input  rtp_hp_pkg::cfg_t      cfg,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rtp_hp_pkg::out_item_t out_data
);

  rtp_hp_pkg::out_item_t result;

  assign pop = rd_valid & (~out_valid | ~out_stall);

  always_comb begin
    result = '0;
    result.status = rd_rec.status;
    // only a good RTP packet reports its fields
    if (rd_rec.status == rtp_hp_pkg::ST_OK) begin
      result.header_length   = rd_rec.header_end;
      result.seq_number      = rd_rec.seq;
      result.sync_source     = (rd_rec.kind == cfg.retransmit_type) ? rd_rec.ssrc : 32'd0;
      result.type_unexpected = (rd_rec.kind != cfg.expected_type);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

endmodule

@@ rtl/rtp_header_parser_unit.sv @@
// RTP header parser (RFC 3550 layout) over a UDP payload stream. It takes one
// byte per clock while the input is not stalled, with no gaps needed between
// packets, and gives one result word per packet after the final byte is taken.
// A front stage tracks position, CSRC count, extension length, sequence number
// and SSRC byte by byte and classifies the packet; a queue of QUEUE_DEPTH packet
// summaries feeds the back stage, which formats the result into the output
// register. The input stalls only while that queue is full, so a stalled output
// holds up the byte stream only after QUEUE_DEPTH further packets have
// completed. Configuration writes are always ready and belong in idle periods.
// Depends on rtp_hp_pkg, rtp_hp_front, rtp_hp_queue and rtp_hp_back.
module rtp_header_parser_unit #(
  parameter int MAX_PACKET_BYTES = rtp_hp_pkg::DEF_MAX_PACKET_BYTES,
  parameter int QUEUE_DEPTH      = rtp_hp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rtp_hp_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rtp_hp_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  rtp_hp_pkg::cfg_t    cfg;
  rtp_hp_pkg::record_t wr_rec, rd_rec;
  logic                push, pop, full, rd_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_length      <= rtp_hp_pkg::RST_MIN_LENGTH;
      cfg.expected_type   <= rtp_hp_pkg::RST_EXPECTED_TYPE;
      cfg.retransmit_type <= rtp_hp_pkg::RST_RETRANSMIT_TYPE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtp_hp_pkg::CFG_MIN_LENGTH:      cfg.min_length      <= cfg_data;
        rtp_hp_pkg::CFG_EXPECTED_TYPE:   cfg.expected_type   <= cfg_data[6:0];
        rtp_hp_pkg::CFG_RETRANSMIT_TYPE: cfg.retransmit_type <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  rtp_hp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .full     (full),
    .push     (push),
    .rec      (wr_rec)
  );

  rtp_hp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_rec   (wr_rec),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_rec   (rd_rec),
    .full     (full)
  );

  rtp_hp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd_valid  (rd_valid),
    .rd_rec    (rd_rec),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/rtp_hp_checker.sv @@
// Port-level checker for the RTP header parser, bound to the top level.
// Uses rtp_hp_pkg and the macros in rtp_header_parser_unit_defines.svh.
`include "rtp_header_parser_unit_defines.svh"

module rtp_hp_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input rtp_hp_pkg::out_item_t out_data
);

  logic out_held, good_word, bad_word, status_known, fields_zero, hdr_aligned;

  assign out_held     = out_valid && out_stall;
  assign good_word    = out_valid && (out_data.status == rtp_hp_pkg::ST_OK);
  assign bad_word     = out_valid && (out_data.status != rtp_hp_pkg::ST_OK);
  assign status_known = (out_data.status <= rtp_hp_pkg::ST_TRUNCATED);
  assign fields_zero  = (out_data.header_length == '0) && (out_data.seq_number == '0) &&
                        (out_data.sync_source == '0) && !out_data.type_unexpected;
  assign hdr_aligned  = (out_data.header_length >= 19'd12) &&
                        (out_data.header_length[1:0] == 2'b00);

  `RTP_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled word changed")

  `RTP_ASSERT_NOW(a_status_range, out_valid, status_known, "status code out of range")

  `RTP_ASSERT_NOW(a_fail_zero, bad_word, fields_zero, "failed packet reports non-zero fields")

  `RTP_ASSERT_NOW(a_hdr_len, good_word, hdr_aligned, "header length not whole words from twelve")

endmodule

bind rtp_header_parser_unit rtp_hp_checker u_rtp_hp_checker (.*);
